// File: src/oms_pkg.sv
`default_nettype none

package oms_pkg;

   localparam int CAPACITY_DEFAULT   = 256;
   localparam int VALUE_BITS_DEFAULT = 30;
   localparam int GROUP_SIZE         = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_QUERY  = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_UPDATE = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// File: src/oms_ctrl.sv
`default_nettype none

module oms_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output oms_pkg::ctrl_cmd_type cmd
);
   import oms_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_UPDATE: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: src/oms_datapath.sv
`default_nettype none

module oms_datapath #(
   parameter int CAPACITY   = oms_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = oms_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  oms_pkg::ctrl_cmd_type cmd,
   input  wire  [1:0]            req_operation,
   input  wire  [VALUE_BITS-1:0] req_value,
   output logic [VALUE_BITS-1:0] rsp_min_value,
   output logic [1:0]            rsp_status
);
   import oms_pkg::*;

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_BITS   = NUM_GROUPS * GROUP_SIZE;

   logic [VALUE_BITS-1:0] cell_ff [CAPACITY];
   logic [VALUE_BITS-1:0] cell_in [CAPACITY];
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   op_type                op_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CAPACITY-1:0]   lt_ff;
   logic [CAPACITY-1:0]   lt_in;
   logic [NUM_GROUPS-1:0] group_ff;
   logic [NUM_GROUPS-1:0] group_in;
   logic [PAD_BITS-1:0]   eq_now;
   logic [VALUE_BITS-1:0] min_ff;
   logic [VALUE_BITS-1:0] min_in;
   status_type            status_ff;
   status_type            status_in;
   logic                  found;
   logic                  full;
   logic                  do_insert;
   logic                  do_erase;

   // Each cell compares its entry with the incoming value when the beat is taken.
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cmp
         logic held;
         assign held       = COUNT_BITS'(gi) < count_ff;
         assign lt_in[gi]  = held && (cell_ff[gi] < req_value);
         assign eq_now[gi] = held && (cell_ff[gi] == req_value);
      end
      if (PAD_BITS > CAPACITY) begin : g_pad
         assign eq_now[PAD_BITS-1:CAPACITY] = '0;
      end
      for (gi = 0; gi < NUM_GROUPS; gi++) begin : g_grp
         assign group_in[gi] = |eq_now[gi*GROUP_SIZE +: GROUP_SIZE];
      end
   endgenerate

   assign found     = |group_ff;
   assign full      = count_ff == COUNT_BITS'(CAPACITY);
   assign do_insert = (op_ff == OP_INSERT) && !found && !full;
   assign do_erase  = (op_ff == OP_ERASE) && found;

   // Insert shifts the entries at and above the insertion point up by one;
   // erase pulls the entries above the removed one down by one.
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [VALUE_BITS-1:0] ins_val;
         logic [VALUE_BITS-1:0] del_val;
         if (gi == 0) begin : g_first
            assign ins_val = lt_ff[gi] ? cell_ff[gi] : value_ff;
         end else begin : g_rest
            assign ins_val = lt_ff[gi] ? cell_ff[gi] :
                             (lt_ff[gi-1] ? value_ff : cell_ff[gi-1]);
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign del_val = cell_ff[gi];
         end else begin : g_inner
            assign del_val = lt_ff[gi] ? cell_ff[gi] : cell_ff[gi+1];
         end
         assign cell_in[gi] = do_insert ? ins_val : (do_erase ? del_val : cell_ff[gi]);
      end
   endgenerate

   always_comb begin
      count_in  = count_ff + COUNT_BITS'(do_insert) - COUNT_BITS'(do_erase);
      status_in = ST_OK;
      if ((op_ff == OP_INSERT) && !found && full) begin
         status_in = ST_FULL;
      end else if ((op_ff == OP_ERASE) && !found) begin
         status_in = ST_MISSING;
      end else if (count_in == '0) begin
         status_in = ST_EMPTY;
      end
      min_in = (count_in != '0) ? cell_in[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_value;
         lt_ff    <= lt_in;
         group_ff <= group_in;
      end
      if (cmd.commit) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cell_ff[i] <= cell_in[i];
         end
         min_ff    <= min_in;
         status_ff <= status_in;
      end
   end

   assign rsp_min_value = min_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

// File: src/ordered_min_set_top.sv
// Ordered minimum set: holds up to CAPACITY distinct values in ascending
// order and reports the smallest one after every operation.
// The request channel (req_valid, req_ready, req_operation, req_value) takes
// one beat per operation: insert, erase, or query the minimum.
// The response channel (rsp_valid, rsp_ready, rsp_min_value, rsp_status)
// returns exactly one beat per request with the minimum held afterwards and
// a status: ok, set empty, insert dropped because the set is full, or erase
// of a value that is not present.
// A request is compared against all entries in the cycle it is taken, and the
// shift of the entry row is applied in the update state, which also loads the
// response register. No new request is taken until that update is done.
// The cost is set by the per-entry compare followed by the row shift.
// A new request may be taken while the previous response still waits; if the
// receiver stalls, the update waits until the response register is free and
// no further request is taken.
// Synchronous reset empties the set and clears the response channel; the
// block can take a request in the first cycle after reset.
`default_nettype none

module ordered_min_set_top #(
   parameter int CAPACITY   = oms_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = oms_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [1:0]            req_operation,
   input  wire  [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_min_value,
   output logic [1:0]            rsp_status
);
   import oms_pkg::*;

   ctrl_cmd_type cmd;

   oms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   oms_datapath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_min_value (rsp_min_value),
      .rsp_status    (rsp_status)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous update is pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_min_value == '0))
      else $error("empty set reported with a nonzero minimum");

   assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("channels not cleared after reset");

endmodule

`default_nettype wire
